// ----- rtl/cdu_pkg.sv -----
// ----------------------------------------------------------------------------
// cdu_pkg
// shared types, constants and calendar tables for the calendar date unit
// ----------------------------------------------------------------------------
package cdu_pkg;

  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int DOY_W   = 9;
  localparam int ADD_W   = 12;
  localparam int QUOT_W  = 8;   // year / 100 never exceeds 163

  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2000;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
  localparam logic [15:0]        MAX_ADVANCE = 16'd4095;

  // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for 14-bit years
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam int          PROD_W      = YEAR_W + 13;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADV = 2'd1,
    OP_CMP = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } ord_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch request, clear result flags
    logic lsel_in;    // leap unit works on the request year
    logic leap_mul;   // leap unit: quotient by 100
    logic leap_fin;   // leap unit: remainder and leap flag
    logic set_try;    // load request date if valid
    logic walk;       // one month step of an advance
    logic cmp;        // compare request date with stored date
    logic load_out;   // fill the result register
  } cdu_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic walk_more;  // remaining days go past the current month
    logic month_dec;  // stored month is december
  } cdu_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DOY_W-1:0] base;
    unique case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ----- rtl/cdu_dpath.sv -----
// ----------------------------------------------------------------------------
// cdu_dpath
// date registers, leap unit, month walker, compare and result register
// ----------------------------------------------------------------------------
module cdu_dpath import cdu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cdu_cmd_t            cmd,
  output cdu_sts_t            sts,
  input  logic [1:0]          req_opcode,
  input  logic [MONTH_W-1:0]  req_month,
  input  logic [DAY_W-1:0]    req_day,
  input  logic [YEAR_W-1:0]   req_year,
  input  logic [ADD_W-1:0]    req_days,
  output logic [MONTH_W-1:0]  res_month,
  output logic [DAY_W-1:0]    res_day,
  output logic [YEAR_W-1:0]   res_year,
  output logic [DOY_W-1:0]    res_doy,
  output logic                res_accepted,
  output logic [1:0]          res_order,
  output logic                res_wrapped
);

  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [YEAR_W-1:0]  year_r;
  logic               leap_r;

  op_t                op_r;
  logic [MONTH_W-1:0] m_in_r;
  logic [DAY_W-1:0]   d_in_r;
  logic [YEAR_W-1:0]  y_in_r;
  logic               leap_in_r;
  logic [ADD_W-1:0]   rem_r;
  logic [QUOT_W-1:0]  quot_r;
  logic               acc_r;
  ord_t               ord_r;
  logic               wrap_r;

  logic [MONTH_W-1:0] out_month_r;
  logic [DAY_W-1:0]   out_day_r;
  logic [YEAR_W-1:0]  out_year_r;
  logic [DOY_W-1:0]   out_doy_r;
  logic               out_acc_r;
  ord_t               out_ord_r;
  logic               out_wrap_r;

  logic [ADD_W-1:0]   rem_sat;
  logic [YEAR_W-1:0]  lsrc;
  logic [PROD_W-1:0]  prod;
  logic [YEAR_W-1:0]  rem100;
  logic               leap_calc;
  logic               set_ok;
  logic [DAY_W-1:0]   gap;
  logic               more;
  ord_t               ord_calc;

  // saturate the day count
  assign rem_sat = ({4'd0, req_days} > MAX_ADVANCE) ? MAX_ADVANCE[ADD_W-1:0] : req_days;

  // leap unit: quotient by reciprocal, then remainder check
  assign lsrc      = cmd.lsel_in ? y_in_r : year_r;
  assign prod      = PROD_W'(lsrc) * PROD_W'(RECIP_100);
  assign rem100    = lsrc - (YEAR_W'(quot_r) * 14'd100);
  assign leap_calc = (rem100 != '0) ? (lsrc[1:0] == 2'd0) : (quot_r[1:0] == 2'd0);

  assign set_ok = (m_in_r >= 4'd1) && (m_in_r <= MONTH_DEC) && (y_in_r <= YEAR_MAX) &&
                  (d_in_r != '0) && (d_in_r <= month_len(m_in_r, leap_in_r));

  assign gap  = month_len(month_r, leap_r) - day_r;
  assign more = rem_r > ADD_W'(gap);

  always_comb begin
    if (year_r != y_in_r) begin
      ord_calc = (year_r < y_in_r) ? ORD_EARLIER : ORD_LATER;
    end else if (month_r != m_in_r) begin
      ord_calc = (month_r < m_in_r) ? ORD_EARLIER : ORD_LATER;
    end else if (day_r != d_in_r) begin
      ord_calc = (day_r < d_in_r) ? ORD_EARLIER : ORD_LATER;
    end else begin
      ord_calc = ORD_EQUAL;
    end
  end

  // stored date
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r <= MONTH_JAN;
      day_r   <= 5'd1;
      year_r  <= YEAR_RESET;
      leap_r  <= 1'b1;
    end else begin
      if (cmd.set_try && set_ok) begin
        month_r <= m_in_r;
        day_r   <= d_in_r;
        year_r  <= y_in_r;
        leap_r  <= leap_in_r;
      end
      if (cmd.leap_fin && !cmd.lsel_in) begin
        leap_r <= leap_calc;
      end
      if (cmd.walk) begin
        if (more) begin
          day_r <= 5'd1;
          if (month_r >= MONTH_DEC) begin
            month_r <= MONTH_JAN;
            year_r  <= (year_r >= YEAR_MAX) ? '0 : year_r + 14'd1;
          end else begin
            month_r <= month_r + 4'd1;
          end
        end else begin
          day_r <= day_r + rem_r[DAY_W-1:0];
        end
      end
    end
  end

  // request copy, working registers and flags
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(req_opcode);
      m_in_r <= req_month;
      d_in_r <= req_day;
      y_in_r <= req_year;
      rem_r  <= rem_sat;
      acc_r  <= 1'b0;
      ord_r  <= ORD_EARLIER;
      wrap_r <= 1'b0;
    end
    if (cmd.leap_mul) begin
      quot_r <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (cmd.leap_fin && cmd.lsel_in) begin
      leap_in_r <= leap_calc;
    end
    if (cmd.set_try) begin
      acc_r <= set_ok;
    end
    if (cmd.walk && more) begin
      rem_r <= rem_r - ADD_W'(gap) - 12'd1;
      if (month_r >= MONTH_DEC && year_r >= YEAR_MAX) begin
        wrap_r <= 1'b1;
      end
    end
    if (cmd.cmp) begin
      ord_r <= ord_calc;
    end
    if (cmd.load_out) begin
      out_month_r <= month_r;
      out_day_r   <= day_r;
      out_year_r  <= year_r;
      out_doy_r   <= days_before(month_r, leap_r) + DOY_W'(day_r);
      out_acc_r   <= acc_r;
      out_ord_r   <= ord_r;
      out_wrap_r  <= wrap_r;
    end
  end

  assign sts.op        = op_r;
  assign sts.walk_more = more;
  assign sts.month_dec = (month_r >= MONTH_DEC);

  assign res_month    = out_month_r;
  assign res_day      = out_day_r;
  assign res_year     = out_year_r;
  assign res_doy      = out_doy_r;
  assign res_accepted = out_acc_r;
  assign res_order    = out_ord_r;
  assign res_wrapped  = out_wrap_r;

endmodule

// ----- rtl/cdu_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdu_ctrl
// sequencer for set, advance and compare requests and the result handshake
// ----------------------------------------------------------------------------
module cdu_ctrl import cdu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  op_t      in_op,
  output logic     out_valid,
  input  logic     out_ready,
  output cdu_cmd_t cmd,
  input  cdu_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LMUL,
    ST_LFIN,
    ST_SETCHK,
    ST_WALK,
    ST_CMP,
    ST_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.lsel_in  = (sts.op == OP_SET);
    cmd.leap_mul = (state_r == ST_LMUL);
    cmd.leap_fin = (state_r == ST_LFIN);
    cmd.set_try  = (state_r == ST_SETCHK);
    cmd.walk     = (state_r == ST_WALK);
    cmd.cmp      = (state_r == ST_CMP);
    cmd.load_out = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_op)
              OP_SET:  state_r <= ST_LMUL;
              OP_ADV:  state_r <= ST_WALK;
              OP_CMP:  state_r <= ST_CMP;
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_LMUL:   state_r <= ST_LFIN;
        ST_LFIN:   state_r <= (sts.op == OP_SET) ? ST_SETCHK : ST_WALK;
        ST_SETCHK: state_r <= ST_DONE;
        ST_WALK: begin
          if (!sts.walk_more) begin
            state_r <= ST_DONE;
          end else if (sts.month_dec) begin
            state_r <= ST_LMUL;
          end
        end
        ST_CMP:    state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/calendar_date_unit.sv -----
// ----------------------------------------------------------------------------
// calendar_date_unit
// holds one gregorian date; sets it, advances it by a day count, compares it
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | in_opcode, in_month, in_day, in_year,
//           |                       | in_days_to_add
//  result   | out_valid / out_ready | out_cur_month, out_cur_day, out_cur_year,
//           |                       | out_day_of_year, out_accepted, out_order,
//           |                       | out_year_wrapped
//
//  one request at a time; in_ready is high while the sequencer is idle
//  set runs a leap test of the request year (multiply, then check), then the
//  range check; advance runs the month walker, which steps one month per
//  cycle, and each new year reruns the leap unit (multiply, then check)
//  before the walk goes on; compare passes through the compare state, and
//  other opcodes go straight to the result write
//  a result waits in its output register; the next request is taken meanwhile
//  and only its final result write stalls on out_ready
//  synchronous reset loads 1/1/2000 and clears out_valid
//
module calendar_date_unit import cdu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [MONTH_W-1:0]  in_month,
  input  logic [DAY_W-1:0]    in_day,
  input  logic [YEAR_W-1:0]   in_year,
  input  logic [ADD_W-1:0]    in_days_to_add,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MONTH_W-1:0]  out_cur_month,
  output logic [DAY_W-1:0]    out_cur_day,
  output logic [YEAR_W-1:0]   out_cur_year,
  output logic [DOY_W-1:0]    out_day_of_year,
  output logic                out_accepted,
  output logic [1:0]          out_order,
  output logic                out_year_wrapped
);

  // command and status between sequencer and datapath
  cdu_cmd_t cmd;
  cdu_sts_t sts;

  // sequencer: picks the operation, runs the leap unit and the month walker
  cdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (op_t'(in_opcode)),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: stored date, leap flag, walker, compare, result register
  cdu_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_opcode   (in_opcode),
    .req_month    (in_month),
    .req_day      (in_day),
    .req_year     (in_year),
    .req_days     (in_days_to_add),
    .res_month    (out_cur_month),
    .res_day      (out_cur_day),
    .res_year     (out_cur_year),
    .res_doy      (out_day_of_year),
    .res_accepted (out_accepted),
    .res_order    (out_order),
    .res_wrapped  (out_year_wrapped)
  );

endmodule
